// File: rtl/rbffc_pkg.sv
package rbffc_pkg;

    // width of every position field on the ports
    localparam int FIELD_W = 10;
    // positions that a field can name
    localparam int FIELD_SPAN = 1 << FIELD_W;

    localparam int DEF_POSITIONS = 1024;
    localparam int DEF_WORD_BITS = 64;

    // operation codes
    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_INVERT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // input beat
    typedef struct packed {
        t_op                operation;
        logic [FIELD_W-1:0] range_low;
        logic [FIELD_W-1:0] range_high;
    } t_in;

    // result beat
    typedef struct packed {
        logic [FIELD_W-1:0] first_clear;
        logic               all_set;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic rd_en;
        logic proc;
        logic find;
    } t_ctl;

endpackage

// File: rtl/rbffc_ctrl.sv
module rbffc_ctrl #(
    parameter int STORED_WORDS = 16,
    parameter int IDX_W        = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 o_valid,
    output rbffc_pkg::t_ctl      o_ctl,
    output logic [IDX_W-1:0]     o_rd_addr
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORED_WORDS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PASS  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIND  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_pend;
    logic             r_done;

    // next state and word counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_PASS;
                    n_cnt   = '0;
                end
            end
            S_PASS: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FIND;
            end
            S_FIND: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= (r_state == S_PASS);
            r_done  <= (r_state == S_FIND);
        end
    end

    // commands
    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_done;
    assign o_ctl.load   = (r_state == S_IDLE) && start;
    assign o_ctl.rd_en  = (r_state == S_PASS);
    assign o_ctl.proc   = r_pend;
    assign o_ctl.find   = (r_state == S_FIND);
    assign o_rd_addr    = r_cnt;

endmodule

// File: rtl/rbffc_dp.sv
module rbffc_dp #(
    parameter int POSITIONS    = 1024,
    parameter int WORD_BITS    = 64,
    parameter int WORD_COUNT   = 16,
    parameter int STORED_WORDS = 16,
    parameter int IDX_W        = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbffc_pkg::t_ctl      i_ctl,
    input  logic [IDX_W-1:0]     i_rd_addr,
    input  rbffc_pkg::t_in       i_item,
    output rbffc_pkg::t_out      o_result
);

    // first position past the stored words, always clear when it exists
    localparam int BEYOND_POS = STORED_WORDS * WORD_BITS;

    logic [WORD_BITS-1:0]  r_mem [STORED_WORDS];
    logic [STORED_WORDS-1:0] r_wvalid;

    rbffc_pkg::t_in        r_item;
    logic [WORD_BITS-1:0]  r_rd_data;
    logic                  r_rd_ok;
    logic [IDX_W-1:0]      r_rd_idx;

    logic                  r_found;
    logic [IDX_W-1:0]      r_found_idx;
    logic [WORD_BITS-1:0]  r_found_free;

    rbffc_pkg::t_out       r_res;

    logic [WORD_BITS-1:0]  word_in;
    logic [WORD_BITS-1:0]  upd_mask;
    logic [WORD_BITS-1:0]  pos_mask;
    logic [WORD_BITS-1:0]  n_word;
    logic [WORD_BITS-1:0]  free_bits;
    logic [31:0]           word_base;

    logic [31:0]           find_pos;
    logic                  find_none;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
    end

    // write valid bits, an unwritten word reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (i_ctl.proc) begin
            r_wvalid[r_rd_idx] <= 1'b1;
        end
    end

    // map memory, registered read and write-back of the word read last cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_ok   <= r_wvalid[i_rd_addr];
            r_rd_idx  <= i_rd_addr;
        end
        if (i_ctl.proc) begin
            r_mem[r_rd_idx] <= n_word;
        end
    end

    // range mask and update of one word
    always_comb begin
        logic [31:0] pos;
        word_in   = r_rd_ok ? r_rd_data : '0;
        word_base = 32'(r_rd_idx) * 32'(WORD_BITS);
        for (int k = 0; k < WORD_BITS; k++) begin
            pos         = word_base + 32'(k);
            pos_mask[k] = (pos < 32'(POSITIONS));
            upd_mask[k] = pos_mask[k]
                          && (pos >= 32'(r_item.range_low))
                          && (pos <= 32'(r_item.range_high));
        end
        case (r_item.operation)
            rbffc_pkg::OP_SET:    n_word = word_in | upd_mask;
            rbffc_pkg::OP_CLEAR:  n_word = word_in & ~upd_mask;
            rbffc_pkg::OP_INVERT: n_word = word_in ^ upd_mask;
            default:              n_word = word_in;
        endcase
        free_bits = ~n_word & pos_mask;
    end

    // remember the first word with a clear bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.load) begin
            r_found <= 1'b0;
        end else if (i_ctl.proc && !r_found && (free_bits != '0)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.proc && !r_found && (free_bits != '0)) begin
            r_found_idx  <= r_rd_idx;
            r_found_free <= free_bits;
        end
    end

    // lowest clear bit of the found word
    always_comb begin
        logic [31:0] k_sel;
        k_sel = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (r_found_free[k]) begin
                k_sel = 32'(k);
            end
        end
        find_none = 1'b0;
        if (r_found) begin
            find_pos = 32'(r_found_idx) * 32'(WORD_BITS) + k_sel;
        end else if (STORED_WORDS < WORD_COUNT) begin
            find_pos = 32'(BEYOND_POS);
        end else begin
            find_pos  = '0;
            find_none = 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.find) begin
            r_res.first_clear <= find_pos[rbffc_pkg::FIELD_W-1:0];
            r_res.all_set     <= find_none;
        end
    end

    assign o_result = r_res;

endmodule

// File: rtl/range_bitmap_find_first_clear_core.sv
// Bitmap of POSITIONS bits, all clear after reset. Each beat accepted on
// start (while busy is low) sets, clears or inverts an inclusive range of
// positions, then the lowest clear position is reported for one cycle on
// o_result with o_valid; all_set is raised with first_clear zero when no
// position is clear. A reversed range or operation code 3 leaves the map as
// it is. Only the words that a 10-bit position can reach are stored, in a
// single memory walked one word per cycle by a read-modify-write pass. The
// result strobe follows the pass, a drain state and a find state, from which
// it is registered; busy is low in the strobe cycle so the next beat can be
// taken there. The receiver cannot hold a result off; it must take it in its
// strobe cycle.
module range_bitmap_find_first_clear_core #(
    parameter int POSITIONS = rbffc_pkg::DEF_POSITIONS,
    parameter int WORD_BITS = rbffc_pkg::DEF_WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  rbffc_pkg::t_in   i_cmd,
    output logic             o_valid,
    output rbffc_pkg::t_out  o_result
);

    localparam int WORD_COUNT   = (POSITIONS + WORD_BITS - 1) / WORD_BITS;
    localparam int REACH        = (POSITIONS < rbffc_pkg::FIELD_SPAN) ?
                                  POSITIONS : rbffc_pkg::FIELD_SPAN;
    localparam int STORED_WORDS = (REACH + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W        = (STORED_WORDS > 1) ? $clog2(STORED_WORDS) : 1;

    rbffc_pkg::t_ctl   ctl;
    logic [IDX_W-1:0]  rd_addr;

    rbffc_ctrl #(
        .STORED_WORDS (STORED_WORDS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_valid   (o_valid),
        .o_ctl     (ctl),
        .o_rd_addr (rd_addr)
    );

    rbffc_dp #(
        .POSITIONS    (POSITIONS),
        .WORD_BITS    (WORD_BITS),
        .WORD_COUNT   (WORD_COUNT),
        .STORED_WORDS (STORED_WORDS),
        .IDX_W        (IDX_W)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_rd_addr (rd_addr),
        .i_item    (i_cmd),
        .o_result  (o_result)
    );

    // result strobe only once the pass is over
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // a result always follows a pass
    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without work");

    // an accepted beat starts a pass
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not start a pass");

    // full map reports position zero
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.all_set) |-> (o_result.first_clear == '0))
        else $error("all_set with nonzero first_clear");

endmodule
